// File: src/cass_pkg.sv
package cass_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 64;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 7;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = $clog2(STACK_DEPTH);

    localparam logic [KIND_W-1:0] K_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] K_POP     = 2'd1;
    localparam logic [KIND_W-1:0] K_UNWIND  = 2'd2;
    localparam logic [KIND_W-1:0] K_REFRESH = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DOWN,
        OP_UP
    } t_shift;

    typedef struct packed {
        t_shift              op;
        logic [DATA_W-1:0]   head;
    } t_chain_ctl;

endpackage

// File: src/cass_cell.sv
module cass_cell (
    input  logic                        i_clk,
    input  cass_pkg::t_shift            i_op,
    input  logic [cass_pkg::DATA_W-1:0] i_prev,
    input  logic [cass_pkg::DATA_W-1:0] i_next,
    output logic [cass_pkg::DATA_W-1:0] o_data
);

    logic [cass_pkg::DATA_W-1:0] r_data;
    logic [cass_pkg::DATA_W-1:0] n_data;

    always_comb begin
        case (i_op)
            cass_pkg::OP_DOWN: n_data = i_prev;
            cass_pkg::OP_UP:   n_data = i_next;
            default:           n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: src/cass_chain.sv
module cass_chain (
    input  logic                        i_clk,
    input  cass_pkg::t_chain_ctl        i_ctl,
    output logic [cass_pkg::DATA_W-1:0] o_top,
    output logic [cass_pkg::DATA_W-1:0] o_bottom
);

    logic [cass_pkg::DATA_W-1:0] w_data [cass_pkg::STACK_DEPTH];

    // cell 0 holds the top entry, higher cells hold older entries
    for (genvar g = 0; g < cass_pkg::STACK_DEPTH; g++) begin : g_cell
        logic [cass_pkg::DATA_W-1:0] w_prev;
        logic [cass_pkg::DATA_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_ctl.head;
        end else begin : g_mid_prev
            assign w_prev = w_data[g-1];
        end

        if (g == cass_pkg::STACK_DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid_next
            assign w_next = w_data[g+1];
        end

        cass_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (i_ctl.op),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[g])
        );
    end

    assign o_top    = w_data[0];
    assign o_bottom = w_data[cass_pkg::STACK_DEPTH-1];

endmodule

// File: src/canary_address_shadow_stack.sv
// Shadow stack of canary addresses held in a chain of cells, top entry in the first cell.
// Push and pop can follow back to back while the output is free; the result is registered
// when the item is taken and comes in the cycle after it. Unwind takes the item, then drops
// entries from the top one by one while the top address is below the given address, then
// gives its result. Refresh of a non-empty stack takes the item, then the whole chain
// rotates once as a ring, the first STACK_DEPTH minus depth steps silent, then one write
// item per cycle from the last cell, bottom entry first; the ring is back in place at the
// end. Refresh of an empty stack gives its result as soon as it is taken. New items are
// taken only once the previous item has finished and its result can be stored; a stalled
// output holds each pending result, and the ring with it, until the result is taken.
module canary_address_shadow_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cass_pkg::KIND_W-1:0]   i_kind,
    input  logic [cass_pkg::DATA_W-1:0]   i_address,
    input  logic [cass_pkg::DATA_W-1:0]   i_canary_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cass_pkg::STATUS_W-1:0] o_status,
    output logic [cass_pkg::DEPTH_W-1:0]  o_depth,
    output logic                          o_write_valid,
    output logic [cass_pkg::DATA_W-1:0]   o_write_address,
    output logic [cass_pkg::DATA_W-1:0]   o_write_value,
    output logic                          o_last
);

    localparam int SUM_W = cass_pkg::CNT_W + 1;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_UNWIND  = 2'd1;
    localparam logic [1:0] S_REFRESH = 2'd2;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [cass_pkg::CNT_W-1:0]    r_count;
    logic [cass_pkg::CNT_W-1:0]    n_count;
    logic [cass_pkg::STEP_W-1:0]   r_step;
    logic [cass_pkg::STEP_W-1:0]   n_step;
    logic [cass_pkg::DATA_W-1:0]   r_sp;
    logic [cass_pkg::DATA_W-1:0]   n_sp;
    logic [cass_pkg::DATA_W-1:0]   r_cval;
    logic [cass_pkg::DATA_W-1:0]   n_cval;

    logic                          r_out_valid;
    logic [cass_pkg::STATUS_W-1:0] r_status;
    logic [cass_pkg::DEPTH_W-1:0]  r_depth;
    logic                          r_write_valid;
    logic [cass_pkg::DATA_W-1:0]   r_write_address;
    logic [cass_pkg::DATA_W-1:0]   r_write_value;
    logic                          r_last;

    logic                          w_out_free;
    logic                          w_accept;
    logic                          w_late;
    logic                          w_emit;
    logic [cass_pkg::STATUS_W-1:0] w_status;
    logic                          w_wv;
    logic [cass_pkg::DATA_W-1:0]   w_wa;
    logic [cass_pkg::DATA_W-1:0]   w_wval;
    logic                          w_last;

    cass_pkg::t_chain_ctl          w_ctl;
    logic [cass_pkg::DATA_W-1:0]   w_top;
    logic [cass_pkg::DATA_W-1:0]   w_bottom;

    cass_chain u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .o_top    (w_top),
        .o_bottom (w_bottom)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    // bottom entry reaches the last cell after depth-complement rotations
    assign w_late = (SUM_W'(r_step) + SUM_W'(r_count)) >= SUM_W'(cass_pkg::STACK_DEPTH);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_step    = r_step;
        n_sp      = r_sp;
        n_cval    = r_cval;
        w_ctl.op  = cass_pkg::OP_HOLD;
        w_ctl.head = i_address;
        w_emit    = 1'b0;
        w_status  = cass_pkg::ST_OK;
        w_wv      = 1'b0;
        w_wa      = '0;
        w_wval    = '0;
        w_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        cass_pkg::K_PUSH: begin
                            w_emit = 1'b1;
                            if (r_count == cass_pkg::CNT_W'(cass_pkg::STACK_DEPTH)) begin
                                w_status = cass_pkg::ST_OVERFLOW;
                            end else begin
                                w_ctl.op = cass_pkg::OP_DOWN;
                                n_count  = r_count + 1'b1;
                                if (r_count == cass_pkg::CNT_W'(cass_pkg::STACK_DEPTH - 1)) begin
                                    w_status = cass_pkg::ST_FULL;
                                end
                            end
                        end
                        cass_pkg::K_POP: begin
                            w_emit = 1'b1;
                            if (r_count == '0) begin
                                w_status = cass_pkg::ST_UNDERFLOW;
                            end else begin
                                w_ctl.op = cass_pkg::OP_UP;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        cass_pkg::K_UNWIND: begin
                            n_sp    = i_address;
                            n_state = S_UNWIND;
                        end
                        default: begin
                            n_cval = i_canary_value;
                            if (r_count == '0) begin
                                w_emit = 1'b1;
                            end else begin
                                n_step  = '0;
                                n_state = S_REFRESH;
                            end
                        end
                    endcase
                end
            end
            S_UNWIND: begin
                if ((r_count != '0) && (w_top < r_sp)) begin
                    w_ctl.op = cass_pkg::OP_UP;
                    n_count  = r_count - 1'b1;
                end else if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_REFRESH: begin
                if (!w_late || w_out_free) begin
                    w_ctl.op   = cass_pkg::OP_DOWN;
                    w_ctl.head = w_bottom;
                    n_step     = r_step + 1'b1;
                    if (w_late) begin
                        w_emit = 1'b1;
                        w_wv   = 1'b1;
                        w_wa   = w_bottom;
                        w_wval = r_cval;
                        w_last = (r_step == cass_pkg::STEP_W'(cass_pkg::STACK_DEPTH - 1));
                    end
                    if (r_step == cass_pkg::STEP_W'(cass_pkg::STACK_DEPTH - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp   <= n_sp;
        r_cval <= n_cval;
        if (w_out_free && w_emit) begin
            r_status        <= w_status;
            r_depth         <= cass_pkg::DEPTH_W'(n_count);
            r_write_valid   <= w_wv;
            r_write_address <= w_wa;
            r_write_value   <= w_wval;
            r_last          <= w_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_depth         = r_depth;
    assign o_write_valid   = r_write_valid;
    assign o_write_address = r_write_address;
    assign o_write_value   = r_write_value;
    assign o_last          = r_last;

endmodule

// File: test/tb_canary_address_shadow_stack.sv
`timescale 1ns / 100ps

module tb_canary_address_shadow_stack;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 375;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [cass_pkg::STATUS_W-1:0] status;
        logic [cass_pkg::DEPTH_W-1:0]  depth;
        logic                          write_valid;
        logic [cass_pkg::DATA_W-1:0]   write_address;
        logic [cass_pkg::DATA_W-1:0]   write_value;
        logic                          last;
    } t_canary_result;

    typedef struct {
        logic [cass_pkg::KIND_W-1:0]   op_kind;
        logic [cass_pkg::DATA_W-1:0]   addr;
        logic [cass_pkg::DATA_W-1:0]   cval;
        int                            reps;
        bit                            fixed;
        logic [cass_pkg::STATUS_W-1:0] status;
        logic [cass_pkg::DEPTH_W-1:0]  depth;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_stall;
    logic [cass_pkg::KIND_W-1:0]   i_kind          = cass_pkg::K_PUSH;
    logic [cass_pkg::DATA_W-1:0]   i_address       = '0;
    logic [cass_pkg::DATA_W-1:0]   i_canary_value  = '0;
    logic                          o_out_valid;
    logic                          i_out_stall     = 1'b0;
    logic [cass_pkg::STATUS_W-1:0] o_status;
    logic [cass_pkg::DEPTH_W-1:0]  o_depth;
    logic                          o_write_valid;
    logic [cass_pkg::DATA_W-1:0]   o_write_address;
    logic [cass_pkg::DATA_W-1:0]   o_write_value;
    logic                          o_last;

    // fixed expectation travels with the item it belongs to
    bit                            row_fixed        = 1'b0;
    t_canary_result                row_fixed_result = '0;

    logic [cass_pkg::DATA_W-1:0]   shadow_addr [cass_pkg::STACK_DEPTH];
    int                            shadow_depth = 0;
    t_canary_result                step_results [$];
    t_canary_result                stack_results_due [$];

    bit                  steady = 1'b0;
    int                  cycle_count = 0;
    int                  mismatch_count = 0;
    int                  items_taken = 0;
    int                  results_checked = 0;
    int                  writes_seen = 0;
    int                  full_seen = 0;
    int                  overflow_seen = 0;
    int                  underflow_seen = 0;

    t_stim_row directed_rows [21] = '{
        '{cass_pkg::K_POP,     64'd0,                  64'd0,                  1,  1'b1,
          cass_pkg::ST_UNDERFLOW, 7'd0},
        '{cass_pkg::K_REFRESH, 64'd0,                  '1,                     1,  1'b1,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_UNWIND,  '1,                     64'd0,                  1,  1'b1,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_PUSH,    64'd0,                  '1,                     1,  1'b1,
          cass_pkg::ST_OK,        7'd1},
        '{cass_pkg::K_PUSH,    '1,                     64'd0,                  1,  1'b1,
          cass_pkg::ST_OK,        7'd2},
        '{cass_pkg::K_PUSH,    64'h8000_0000_0000_0000, 64'd0,                 1,  1'b1,
          cass_pkg::ST_OK,        7'd3},
        '{cass_pkg::K_REFRESH, 64'd0,                  64'd0,                  1,  1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_REFRESH, 64'd0,                  '1,                     1,  1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_UNWIND,  64'h8000_0000_0000_0000, 64'd0,                 1,  1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_UNWIND,  64'h8000_0000_0000_0001, 64'd0,                 1,  1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_POP,     64'd0,                  64'd0,                  1,  1'b1,
          cass_pkg::ST_OK,        7'd1},
        '{cass_pkg::K_PUSH,    64'd0,                  64'd0,                  62, 1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_PUSH,    64'h5555_5555_5555_5555, 64'd0,                 1,  1'b1,
          cass_pkg::ST_FULL,      7'd64},
        '{cass_pkg::K_PUSH,    64'hAAAA_AAAA_AAAA_AAAA, 64'd0,                 1,  1'b1,
          cass_pkg::ST_OVERFLOW,  7'd64},
        '{cass_pkg::K_POP,     64'd0,                  64'd0,                  1,  1'b1,
          cass_pkg::ST_OK,        7'd63},
        '{cass_pkg::K_PUSH,    64'd0,                  64'd0,                  1,  1'b1,
          cass_pkg::ST_FULL,      7'd64},
        '{cass_pkg::K_REFRESH, 64'd0,                  64'hA5A5_A5A5_A5A5_A5A5, 1, 1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_UNWIND,  '1,                     64'd0,                  1,  1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_UNWIND,  64'd0,                  64'd0,                  1,  1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_POP,     64'd0,                  64'd0,                  4,  1'b0,
          cass_pkg::ST_OK,        7'd0},
        '{cass_pkg::K_REFRESH, 64'd0,                  64'd1,                  1,  1'b0,
          cass_pkg::ST_OK,        7'd0}
    };

    canary_address_shadow_stack dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_address       (i_address),
        .i_canary_value  (i_canary_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_depth         (o_depth),
        .o_write_valid   (o_write_valid),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // results the stack owes for one item, left in step_results
    task automatic predict_stack_step(input logic [cass_pkg::KIND_W-1:0] op_kind,
                                      input logic [cass_pkg::DATA_W-1:0] addr,
                                      input logic [cass_pkg::DATA_W-1:0] cval);
        t_canary_result res;
        res = '0;
        res.last = 1'b1;
        res.status = cass_pkg::ST_OK;
        step_results.delete();
        case (op_kind)
            cass_pkg::K_PUSH: begin
                if (shadow_depth >= cass_pkg::STACK_DEPTH) begin
                    res.status = cass_pkg::ST_OVERFLOW;
                end else begin
                    shadow_addr[shadow_depth] = addr;
                    shadow_depth++;
                    if (shadow_depth == cass_pkg::STACK_DEPTH)
                        res.status = cass_pkg::ST_FULL;
                end
            end
            cass_pkg::K_POP: begin
                if (shadow_depth == 0)
                    res.status = cass_pkg::ST_UNDERFLOW;
                else
                    shadow_depth--;
            end
            cass_pkg::K_UNWIND: begin
                while (shadow_depth > 0 && shadow_addr[shadow_depth-1] < addr)
                    shadow_depth--;
            end
            default: begin
                for (int k = 0; k < shadow_depth; k++) begin
                    res.write_valid   = 1'b1;
                    res.write_address = shadow_addr[k];
                    res.write_value   = cval;
                    res.last          = (k == shadow_depth - 1);
                    res.depth         = cass_pkg::DEPTH_W'(shadow_depth);
                    step_results.push_back(res);
                end
            end
        endcase
        if (step_results.size() == 0) begin
            res.depth = cass_pkg::DEPTH_W'(shadow_depth);
            step_results.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [cass_pkg::DATA_W-1:0] got,
                                   input logic [cass_pkg::DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch on %s: got %h want %h (result %0d)",
                     $realtime, what, got, want, results_checked);
    endtask

    task automatic check_field(input string what,
                               input logic [cass_pkg::DATA_W-1:0] got,
                               input logic [cass_pkg::DATA_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_canary_result got;
        t_canary_result want;
        cycle_count++;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_stack_step(i_kind, i_address, i_canary_value);
                items_taken++;
                if (row_fixed)
                    stack_results_due.push_back(row_fixed_result);
                else
                    foreach (step_results[k])
                        stack_results_due.push_back(step_results[k]);
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_status, o_depth, o_write_valid, o_write_address,
                        o_write_value, o_last};
                results_checked++;
                if (got.write_valid === 1'b1) writes_seen++;
                if (got.status === cass_pkg::ST_FULL) full_seen++;
                if (got.status === cass_pkg::ST_OVERFLOW) overflow_seen++;
                if (got.status === cass_pkg::ST_UNDERFLOW) underflow_seen++;
                if (stack_results_due.size() == 0) begin
                    report_mismatch("unexpected result",
                                    cass_pkg::DATA_W'({got.status, got.depth}), '0);
                end else begin
                    want = stack_results_due.pop_front();
                    check_field("status", cass_pkg::DATA_W'(got.status),
                                cass_pkg::DATA_W'(want.status));
                    check_field("depth", cass_pkg::DATA_W'(got.depth),
                                cass_pkg::DATA_W'(want.depth));
                    check_field("write_valid", cass_pkg::DATA_W'(got.write_valid),
                                cass_pkg::DATA_W'(want.write_valid));
                    check_field("write_address", got.write_address, want.write_address);
                    check_field("write_value", got.write_value, want.write_value);
                    check_field("last", cass_pkg::DATA_W'(got.last),
                                cass_pkg::DATA_W'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (steady)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(0, 99) < 30);
    end

    task automatic send_item(input logic [cass_pkg::KIND_W-1:0] op_kind,
                             input logic [cass_pkg::DATA_W-1:0] addr,
                             input logic [cass_pkg::DATA_W-1:0] cval,
                             input bit fixed,
                             input t_canary_result fixed_res);
        while (!steady && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= op_kind;
        i_address        <= addr;
        i_canary_value   <= cval;
        row_fixed        <= fixed;
        row_fixed_result <= fixed_res;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("** canary_address_shadow_stack: FAILED **");
        $finish;
    end

    initial begin
        logic [cass_pkg::KIND_W-1:0] op_kind;
        logic [cass_pkg::DATA_W-1:0] addr;
        logic [cass_pkg::DATA_W-1:0] frame_ptr;
        t_canary_result              fixed;
        int                          burst_mode;
        int                          roll;
        int                          p_push;
        int                          p_pop;
        int                          p_unw;

        frame_ptr  = 64'h0000_7FFF_FFFF_F000;
        burst_mode = 2;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, repeated rows carry random addresses
        foreach (directed_rows[r]) begin
            for (int n = 0; n < directed_rows[r].reps; n++) begin
                addr = (directed_rows[r].reps > 1) ? {$urandom, $urandom}
                                                   : directed_rows[r].addr;
                fixed = '{directed_rows[r].status, directed_rows[r].depth,
                          1'b0, 64'd0, 64'd0, 1'b1};
                send_item(directed_rows[r].op_kind, addr, directed_rows[r].cval,
                          directed_rows[r].fixed, fixed);
            end
        end

        // random phase: fill, drain and mixed bursts over call-like frames
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 180 && n < 280);
            if (n % 40 == 0)
                burst_mode = $urandom_range(0, 2);
            case (burst_mode)
                0: begin p_push = 75; p_pop = 80; p_unw = 90; end
                1: begin p_push = 15; p_pop = 70; p_unw = 90; end
                default: begin p_push = 40; p_pop = 70; p_unw = 85; end
            endcase
            roll = $urandom_range(0, 99);
            addr = {$urandom, $urandom};
            if (roll < p_push) begin
                op_kind = cass_pkg::K_PUSH;
                if ($urandom_range(0, 99) < 85) begin
                    frame_ptr = frame_ptr
                              - cass_pkg::DATA_W'({$urandom_range(1, 64), 4'b0});
                    addr = frame_ptr;
                end
            end else if (roll < p_pop) begin
                op_kind = cass_pkg::K_POP;
                frame_ptr = frame_ptr + 64'd256;
            end else if (roll < p_unw) begin
                op_kind = cass_pkg::K_UNWIND;
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    frame_ptr = frame_ptr
                              + cass_pkg::DATA_W'({$urandom_range(0, 1024), 4'b0});
                    addr = frame_ptr;
                end else if (roll < 68) begin
                    addr = '0;
                end else if (roll < 76) begin
                    addr = '1;
                end
            end else begin
                op_kind = cass_pkg::K_REFRESH;
            end
            send_item(op_kind, addr, {$urandom, $urandom}, 1'b0, '0);
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (stack_results_due.size() != 0)
            @(posedge i_clk);
        repeat (2 * cass_pkg::STACK_DEPTH + 16) @(posedge i_clk);

        $display("%0d items taken, %0d results checked, %0d canary writes",
                 items_taken, results_checked, writes_seen);
        $display("full %0d, dropped push %0d, pop underflow %0d, mismatches %0d",
                 full_seen, overflow_seen, underflow_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("** canary_address_shadow_stack: PASSED **");
        else
            $display("** canary_address_shadow_stack: FAILED **");
        $finish;
    end

endmodule
